// ----- hw/rtl/bb3_pkg.sv -----
// Shared constants, types and the reciprocal table of the 3x3 box blur.
`default_nettype none
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int FW_W          = 12;
    localparam int FH_W          = 16;
    localparam int CH_W          = 8;
    localparam int PIX_W         = 3 * CH_W;
    localparam int SUM_W         = 12;
    localparam int CNT_W         = 4;
    localparam int RECIP_SH      = 16;
    localparam int RECIP_W       = 17;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic       ld_pix;
        logic       rd;
        logic       shift;
        logic       sum;
        logic       mul;
        logic [2:0] row_msk;
        logic [2:0] col_msk;
    } t_dp_cmd;

    // ceil(2^16 / cnt) for every neighbor count that can occur
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bb3_pix_if.sv -----
// Pixel input channel.
`default_nettype none
interface bb3_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bb3_res_if.sv -----
// Blurred pixel output channel.
`default_nettype none
interface bb3_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] blur_red;
    logic [7:0] blur_green;
    logic [7:0] blur_blue;
    logic       frame_last;
    modport source (output valid, blur_red, blur_green, blur_blue, frame_last, input ready);
    modport sink   (input valid, blur_red, blur_green, blur_blue, frame_last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bb3_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- hw/rtl/bb3_ctrl.sv -----
// Sequencer: frame position, emit decisions, clip masks and handshakes.
`default_nettype none
module bb3_ctrl #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [bb3_pkg::FW_W-1:0]     i_frame_width,
    input  wire logic [bb3_pkg::FH_W-1:0]     i_frame_height,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_frame_last,
    output bb3_pkg::t_dp_cmd                  o_cmd,
    output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] o_addr
);
    import bb3_pkg::*;

    localparam int C_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = ((W_W > FW_W) ? W_W : FW_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_SUM   = 5'b00100,
        S_MUL   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        SLOT_TOP = 2'd0,
        SLOT_MID = 2'd1,
        SLOT_END = 2'd2
    } t_slot;

    t_state           r_state, n_state;
    t_slot            r_slot, n_slot;
    logic [C_W-1:0]   r_col, n_col;
    logic [FH_W-1:0]  r_row, n_row;

    logic [CMP_W-1:0] fw_x, wx, colx;
    logic [FH_W:0]    hx, rowx;
    logic             e1, e2, e3, last, row_end, finish;
    logic [2:0]       row_msk, col_msk;

    always_comb begin
        fw_x = CMP_W'(i_frame_width);
        if (i_frame_width == '0) begin
            wx = CMP_W'(1);
        end else if (fw_x > CMP_W'(MAX_WIDTH)) begin
            wx = CMP_W'(MAX_WIDTH);
        end else begin
            wx = fw_x;
        end
        hx   = (i_frame_height == '0) ? (FH_W+1)'(1) : {1'b0, i_frame_height};
        colx = CMP_W'(r_col);
        rowx = {1'b0, r_row};
    end

    // emit decisions for the current position (stable through the item)
    assign e1      = (r_col == '0) && (rowx >= 2) && (rowx < hx + 2);
    assign e2      = (r_col != '0) && (r_row != '0) && (rowx <= hx) && (colx <= wx);
    assign row_end = (colx + 1'b1 >= wx);
    assign last    = (rowx >= hx) && row_end;
    assign e3      = last && (rowx <= hx) && (colx < wx);

    always_comb begin
        unique case (r_slot)
            SLOT_TOP: begin
                row_msk = {rowx <= hx, 1'b1, rowx >= 3};
                col_msk = {1'b1, wx >= 2, wx >= 3};
            end
            SLOT_MID: begin
                row_msk = {rowx < hx, 1'b1, rowx >= 2};
                col_msk = {colx < wx, 1'b1, colx >= 2};
            end
            SLOT_END: begin
                row_msk = {1'b0, 1'b1, rowx >= 2};
                col_msk = {1'b1, colx >= 1, colx >= 2};
            end
            default: begin
                row_msk = 3'b010;
                col_msk = 3'b010;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        finish  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (e1) begin
                        n_slot  = SLOT_TOP;
                        n_state = S_SUM;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (e2) begin
                    n_slot  = SLOT_MID;
                    n_state = S_SUM;
                end else if (e3) begin
                    n_slot  = SLOT_END;
                    n_state = S_SUM;
                end else begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SUM: n_state = S_MUL;
            S_MUL: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_slot == SLOT_TOP) begin
                        n_state = S_SHIFT;
                    end else if (r_slot == SLOT_MID && e3) begin
                        n_slot  = SLOT_END;
                        n_state = S_SUM;
                    end else begin
                        finish  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (finish) begin
            if (last) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= SLOT_TOP;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_frame_last  = (r_slot == SLOT_END);
    assign o_addr        = r_col;
    assign o_cmd.ld_pix  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd      = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.shift   = (r_state == S_SHIFT);
    assign o_cmd.sum     = (r_state == S_SUM);
    assign o_cmd.mul     = (r_state == S_MUL);
    assign o_cmd.row_msk = row_msk;
    assign o_cmd.col_msk = col_msk;
endmodule
`default_nettype wire

// ----- hw/rtl/bb3_dp.sv -----
// Datapath: line memories, 3x3 window, masked sums and reciprocal divide.
`default_nettype none
module bb3_dp #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bb3_pkg::t_dp_cmd              i_cmd,
    input  wire logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] i_addr,
    input  wire logic [bb3_pkg::PIX_W-1:0]     i_pix,
    output logic      [bb3_pkg::CH_W-1:0]      o_red,
    output logic      [bb3_pkg::CH_W-1:0]      o_green,
    output logic      [bb3_pkg::CH_W-1:0]      o_blue
);
    import bb3_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [PIX_W-1:0]   r_pix;
    logic [PIX_W-1:0]   r_win [3][3];
    logic [PIX_W-1:0]   up1, up2;
    logic [SUM_W-1:0]   sum [3];
    logic [SUM_W-1:0]   r_x [3];
    logic [RECIP_W-1:0] r_m;
    logic [CH_W-1:0]    r_q [3];
    logic [1:0]         rcnt, ccnt;
    logic [CNT_W-1:0]   cnt;
    logic [PROD_W-1:0]  prod [3];

    // row above at up1, two rows above at up2
    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_up1 (
        .i_clk  (i_clk),
        .i_we   (i_cmd.shift),
        .i_re   (i_cmd.rd),
        .i_addr (i_addr),
        .i_wdata(r_pix),
        .o_rdata(up1)
    );

    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_up2 (
        .i_clk  (i_clk),
        .i_we   (i_cmd.shift),
        .i_re   (i_cmd.rd),
        .i_addr (i_addr),
        .i_wdata(up1),
        .o_rdata(up2)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_pix) begin
            r_pix <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= up2;
            r_win[1][2] <= up1;
            r_win[2][2] <= r_pix;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (i_cmd.row_msk[i] && i_cmd.col_msk[j]) begin
                        sum[k] = sum[k] + SUM_W'(r_win[i][j][PIX_W-1-CH_W*k -: CH_W]);
                    end
                end
            end
        end
        rcnt = 2'($countones(i_cmd.row_msk));
        ccnt = 2'($countones(i_cmd.col_msk));
        cnt  = {2'b00, rcnt} * {2'b00, ccnt};
    end

    // (2*sum + cnt) / (2*cnt) == (sum + cnt/2) / cnt
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            for (int k = 0; k < 3; k++) begin
                r_x[k] <= sum[k] + SUM_W'(cnt >> 1);
            end
            r_m <= recip(cnt);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = PROD_W'(r_x[k]) * PROD_W'(r_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= prod[k][RECIP_SH +: CH_W];
            end
        end
    end

    assign o_red   = r_q[0];
    assign o_green = r_q[1];
    assign o_blue  = r_q[2];
endmodule
`default_nettype wire

// ----- hw/rtl/box_blur_3x3_rgb_unit.sv -----
// Top level of the streaming 3x3 RGB box blur with its register port.
`default_nettype none
// Streaming 3x3 box blur for 8-bit RGB pixels in raster order. Each output
// pixel carries, per channel, the half-up rounded mean of its 3x3
// neighborhood clipped to the frame (4 at corners, 6 on edges, 9 inside).
// Output trails input by one row plus one pixel; after width*height pixels,
// feed frame_width drain items (payload ignored) to flush the last row. The
// final result of a frame carries frame_last. Registers: frame_width at
// byte 0 (0 acts as 1, values above MAX_WIDTH act as MAX_WIDTH) and
// frame_height at byte 4 (0 acts as 1); write them only while idle.
// An item yields 0, 1 or 2 results and holds the block, output stalls
// included, until all are out. Each result goes through one shared sum
// stage and one shared reciprocal-multiply stage, and the two line memories
// are single ported: read on accept, written when the window shifts, which
// comes after the result for the row two above, if any. No clearing pass:
// line memory contents never written in a frame are never used.
module box_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    bb3_pix_if.sink                                i_pix,
    bb3_res_if.source                              o_res,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bb3_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [bb3_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [bb3_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);
    import bb3_pkg::*;

    localparam int C_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic             wr_en;
    t_dp_cmd          cmd;
    logic [C_W-1:0]   addr;

    // register port: always ready, write lands in the access phase
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_FRAME_WIDTH) begin
                r_frame_width <= pwdata[FW_W-1:0];
            end else begin
                r_frame_height <= pwdata[FH_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_FRAME_HEIGHT) begin
            prdata = APB_DATA_W'(r_frame_height);
        end else begin
            prdata = APB_DATA_W'(r_frame_width);
        end
    end

    bb3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_width (r_frame_width),
        .i_frame_height(r_frame_height),
        .i_in_valid    (i_pix.valid),
        .o_in_ready    (i_pix.ready),
        .o_out_valid   (o_res.valid),
        .i_out_ready   (o_res.ready),
        .o_frame_last  (o_res.frame_last),
        .o_cmd         (cmd),
        .o_addr        (addr)
    );

    bb3_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_addr (addr),
        .i_pix  ({i_pix.red, i_pix.green, i_pix.blue}),
        .o_red  (o_res.blur_red),
        .o_green(o_res.blur_green),
        .o_blue (o_res.blur_blue)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/bb3_chk.sv -----
// Port-level checker for the box blur and its bind to the top level.
`default_nettype none
module bb3_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);
    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after accept");

    // no result is offered while a new item may be taken
    a_ready_excl_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while result pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("not idle after reset");
endmodule

bind box_blur_3x3_rgb_unit bb3_chk u_bb3_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_pix.valid),
    .i_in_ready (i_pix.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready)
);
`default_nettype wire

// ----- tb/sv/tb_box_blur_3x3_rgb_unit.sv -----
// Self-checking testbench for the streaming 3x3 RGB box blur unit.
`timescale 1ns / 100ps
module tb_box_blur_3x3_rgb_unit;
    import bb3_pkg::*;

    localparam int MAXW = MAX_WIDTH_DEF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_blur;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    bb3_pix_if pix_ch ();
    bb3_res_if res_ch ();

    box_blur_3x3_rgb_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Pixel stream waiting for the driver and blurred pixels still owed by the DUT.
    t_pix  pix_queue[$];
    t_blur blur_queue[$];
    int    mismatches;
    int    pixels_sent;
    int    blurs_seen;
    int    frames_run;
    bit    calm;        // set for frames where neither side idles

    // Mirror of the block: registers, line memories, window, raster position.
    logic [FW_W-1:0] cfg_width;
    logic [FH_W-1:0] cfg_height;
    logic [23:0] line_up1 [MAXW];
    logic [23:0] line_up2 [MAXW];
    logic [23:0] win [3][3];
    logic [15:0] row_pos;
    logic [10:0] col_pos;

    // Random gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Clipped-neighborhood mean around image pixel (r, c) at window column jc.
    task automatic push_blur(input int r, input int c, input int jc,
                             input int w, input int h, input logic flag);
        int sum_r, sum_g, sum_b, cnt, nr, nc;
        t_blur b;
        sum_r = 0; sum_g = 0; sum_b = 0; cnt = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                nr = r - 1 + i;
                nc = c + j - jc;
                if (nr >= 0 && nr < h && nc >= 0 && nc < w) begin
                    sum_r += win[i][j][23:16];
                    sum_g += win[i][j][15:8];
                    sum_b += win[i][j][7:0];
                    cnt++;
                end
            end
        end
        if (cnt == 0) cnt = 1;
        b.red   = 8'((2 * sum_r + cnt) / (2 * cnt));
        b.green = 8'((2 * sum_g + cnt) / (2 * cnt));
        b.blue  = 8'((2 * sum_b + cnt) / (2 * cnt));
        b.last  = flag;
        blur_queue.push_back(b);
    endtask

    // Advance the mirror by one accepted pixel and queue what it produces.
    task automatic predict_blur(input t_pix p);
        int w, h, row, col;
        logic [23:0] up1, up2;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAXW) ? MAXW : int'(cfg_width));
        h = (cfg_height == 0) ? 1 : int'(cfg_height);
        row = row_pos;
        col = col_pos;
        // right edge of the row two above comes out first, before the shift
        if (col == 0 && row >= 2 && row - 2 < h) push_blur(row - 2, w - 1, 2, w, h, 1'b0);
        up1 = line_up1[col_pos];
        up2 = line_up2[col_pos];
        line_up2[col_pos] = up1;
        line_up1[col_pos] = p;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = p;
        if (col >= 1 && row >= 1 && row - 1 < h && col - 1 < w)
            push_blur(row - 1, col - 1, 1, w, h, 1'b0);
        if (row >= h && col + 1 >= w) begin
            // final drain item: last pixel of the frame, flagged
            if (row - 1 < h && col < w) push_blur(row - 1, col, 2, w, h, 1'b1);
            row_pos = '0;
            col_pos = '0;
        end else if (col + 1 >= w) begin
            col_pos = '0;
            row_pos = row_pos + 16'd1;
        end else begin
            col_pos = col_pos + 11'd1;
        end
    endtask

    // Driver: holds an item until accepted, then pulls the next after a gap.
    int   src_gap;
    t_pix held;
    always @(posedge i_clk) begin
        logic nxt_valid;
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
            src_gap = 0;
        end else begin
            nxt_valid = pix_ch.valid;
            if (pix_ch.valid && pix_ch.ready) begin
                predict_blur(held);
                pixels_sent++;
                nxt_valid = 1'b0;
                src_gap = gap_len();
            end
            if (!nxt_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pix_queue.size() > 0) begin
                    held = pix_queue.pop_front();
                    pix_ch.red   <= held.red;
                    pix_ch.green <= held.green;
                    pix_ch.blue  <= held.blue;
                    nxt_valid = 1'b1;
                end
            end
            pix_ch.valid <= nxt_valid;
        end
    end

    // Monitor: random backpressure, compares each result with the oldest owed.
    int snk_gap;
    always @(posedge i_clk) begin
        t_blur exp_b;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                blurs_seen++;
                if (blur_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %0d/%0d/%0d last=%0b",
                                 res_ch.blur_red, res_ch.blur_green, res_ch.blur_blue,
                                 res_ch.frame_last);
                end else begin
                    exp_b = blur_queue.pop_front();
                    if (exp_b.red !== res_ch.blur_red || exp_b.green !== res_ch.blur_green
                        || exp_b.blue !== res_ch.blur_blue
                        || exp_b.last !== res_ch.frame_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result %0d exp %0d/%0d/%0d last=%0b",
                                      " got %0d/%0d/%0d last=%0b"},
                                     blurs_seen, exp_b.red, exp_b.green, exp_b.blue,
                                     exp_b.last, res_ch.blur_red, res_ch.blur_green,
                                     res_ch.blur_blue, res_ch.frame_last);
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                snk_gap = gap_len();
            end
        end
    end

    // Two-phase register write, then a read back of the same register.
    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FRAME_WIDTH) cfg_width = val[FW_W-1:0];
        else cfg_height = val[FH_W-1:0];
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== ((idx == REG_FRAME_WIDTH) ? 32'(cfg_width) : 32'(cfg_height))) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: register %0d reads %0h", idx, prdata);
        end
    endtask

    // Wait for the block to go quiet, with slack for its internal pipeline.
    task automatic wait_idle();
        while (pix_queue.size() > 0 || pix_ch.valid || blur_queue.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Queue one whole frame plus its drain row; mode 0 random, 1 extremes.
    task automatic queue_frame(input logic [31:0] w_reg, input logic [31:0] h_reg,
                               input int mode);
        int w, h;
        t_pix p;
        wait_idle();
        reg_write(REG_FRAME_WIDTH, w_reg);
        reg_write(REG_FRAME_HEIGHT, h_reg);
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAXW) ? MAXW : int'(cfg_width));
        h = (cfg_height == 0) ? 1 : int'(cfg_height);
        for (int k = 0; k < (h + 1) * w; k++) begin
            if (mode == 1) begin
                // alternating full-scale and zero channels, with the odd mid value
                p.red   = k[0] ? 8'hff : 8'h00;
                p.green = k[1] ? 8'hff : 8'h00;
                p.blue  = (k % 3 == 0) ? 8'h80 : (k[0] ? 8'h00 : 8'hff);
            end else begin
                p = t_pix'(24'($urandom));
            end
            pix_queue.push_back(p);
        end
        frames_run++;
    endtask

    initial begin
        int w_pick, h_pick;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        pix_ch.valid = 1'b0; pix_ch.red = '0; pix_ch.green = '0; pix_ch.blue = '0;
        res_ch.ready = 1'b0;
        mismatches = 0; pixels_sent = 0; blurs_seen = 0; frames_run = 0;
        calm = 1'b0;
        cfg_width = FRAME_WIDTH_RST;
        cfg_height = FRAME_HEIGHT_RST;
        row_pos = '0; col_pos = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        for (int k = 0; k < MAXW; k++) begin
            line_up1[k] = '0;
            line_up2[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tiny and degenerate frames with saturated pixels
        queue_frame(3, 3, 1);
        queue_frame(1, 1, 1);
        queue_frame(0, 0, 1);       // zero width and height act as one
        queue_frame(2, 1, 1);
        queue_frame(1, 4, 1);

        // random small frames, gaps on both sides unless calm
        while (pixels_sent + pix_queue.size() < 850) begin
            calm = ($urandom_range(0, 5) == 0);
            w_pick = $urandom_range(1, 12);
            h_pick = $urandom_range(1, 9);
            queue_frame(w_pick, h_pick, 0);
        end

        // a tall one-pixel-wide frame, then a mid-size one to close
        calm = 1'b1;
        queue_frame(1, 300, 0);
        calm = 1'b0;
        queue_frame(7, 5, 0);

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d frames: %0d pixels in, %0d blurred pixels out.",
                 frames_run, pixels_sent, blurs_seen);
        $display("Sizes from 1x1 up to 12 wide and 300 tall, with zero-valued registers.");
        if (mismatches == 0 && blur_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/bb3_pkg.sv
hw/rtl/bb3_pix_if.sv
hw/rtl/bb3_res_if.sv
hw/rtl/bb3_ram.sv
hw/rtl/bb3_ctrl.sv
hw/rtl/bb3_dp.sv
hw/rtl/box_blur_3x3_rgb_unit.sv
hw/rtl/bb3_chk.sv
tb/sv/tb_box_blur_3x3_rgb_unit.sv
